### design/group_one_address_mode_unit_assert.svh
// Assertion macros shared by the group one addressing unit.
`ifndef GROUP_ONE_ADDRESS_MODE_UNIT_ASSERT_SVH
`define GROUP_ONE_ADDRESS_MODE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GOM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GOM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/gom_pkg.sv
// Types and constants shared by the group one addressing unit.
package gom_pkg;

    localparam int unsigned InTdataW  = 40;
    localparam int unsigned OutTdataW = 40;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_INVALID = 2'd2,
        KIND_NOT_G1  = 2'd3
    } t_kind;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_DATA  = 1'b1
    } t_action;

    localparam logic [1:0] GROUP_ONE_CC = 2'b01;
    localparam logic [2:0] MODE_ZP_X_IND = 3'd0;
    localparam logic [2:0] MODE_ZP       = 3'd1;
    localparam logic [2:0] MODE_IMM      = 3'd2;
    localparam logic [2:0] MODE_IND_Y    = 3'd4;
    localparam logic [2:0] MODE_ZP_X     = 3'd5;
    localparam logic [2:0] MODE_ABS_Y    = 3'd6;
    localparam logic [2:0] MODE_ABS_X    = 3'd7;

    typedef struct packed {
        t_action     action;
        logic [15:0] start_pc;
        logic [7:0]  x_index;
        logic [7:0]  y_index;
        logic [7:0]  read_data;
    } t_in_beat;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] address;
        logic [15:0] next_pc;
        logic [2:0]  operation;
    } t_result;

endpackage

### design/gom_in_stage.sv
// Input register that holds one accepted beat until the core takes it.
module gom_in_stage
    import gom_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_beat i_beat,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_beat o_beat
);

    logic     r_valid;
    t_in_beat r_beat;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

### design/gom_core.sv
// Sequencer state and the one-step address calculation for each beat.
module gom_core
    import gom_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_beat i_beat,
    output logic     o_res_valid,
    output t_result  o_res,
    output logic     o_busy
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_OPCODE  = 3'd1,
        PH_OPER_LO = 3'd2,
        PH_OPER_HI = 3'd3,
        PH_PTR_LO  = 3'd4,
        PH_PTR_HI  = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_x, n_x;
    logic [7:0]  r_y, n_y;
    logic [2:0]  r_mode, n_mode;
    logic [2:0]  r_op, n_op;
    logic [7:0]  r_zp, n_zp;
    logic [7:0]  r_lo, n_lo;

    logic [15:0] pc_inc;
    logic [15:0] word;
    logic [7:0]  data;

    assign data   = i_beat.read_data;
    assign pc_inc = r_pc + 16'd1;
    assign word   = {data, r_lo};
    assign o_busy = (r_phase != PH_IDLE);

    always_comb begin
        n_phase = r_phase;
        n_pc    = r_pc;
        n_x     = r_x;
        n_y     = r_y;
        n_mode  = r_mode;
        n_op    = r_op;
        n_zp    = r_zp;
        n_lo    = r_lo;
        o_res_valid = 1'b1;
        o_res.kind      = KIND_READ;
        o_res.address   = r_pc;
        o_res.next_pc   = r_pc;
        o_res.operation = r_op;

        if (i_beat.action == ACT_START) begin
            n_phase = PH_OPCODE;
            n_pc    = i_beat.start_pc;
            n_x     = i_beat.x_index;
            n_y     = i_beat.y_index;
            n_mode  = 3'd0;
            n_op    = 3'd0;
            n_zp    = 8'd0;
            n_lo    = 8'd0;
            o_res.address   = i_beat.start_pc;
            o_res.next_pc   = i_beat.start_pc;
            o_res.operation = 3'd0;
        end else begin
            unique case (r_phase)
                PH_OPCODE: begin
                    n_pc = pc_inc;
                    o_res.next_pc = pc_inc;
                    if (data == 8'd0) begin
                        n_phase = PH_IDLE;
                        o_res.kind      = KIND_INVALID;
                        o_res.operation = 3'd0;
                    end else begin
                        n_op   = data[7:5];
                        n_mode = data[4:2];
                        o_res.operation = data[7:5];
                        if (data[1:0] != GROUP_ONE_CC) begin
                            n_phase = PH_IDLE;
                            o_res.kind = KIND_NOT_G1;
                        end else if (data[4:2] == MODE_IMM) begin
                            // The immediate byte itself is the operand address.
                            n_phase = PH_IDLE;
                            n_pc    = pc_inc + 16'd1;
                            o_res.kind    = KIND_DONE;
                            o_res.address = pc_inc;
                            o_res.next_pc = pc_inc + 16'd1;
                        end else begin
                            n_phase = PH_OPER_LO;
                            o_res.address = pc_inc;
                        end
                    end
                end
                PH_OPER_LO: begin
                    n_pc = pc_inc;
                    o_res.next_pc = pc_inc;
                    unique case (r_mode)
                        MODE_ZP_X_IND: begin
                            n_zp    = data + r_x;
                            n_phase = PH_PTR_LO;
                            o_res.address = {8'd0, data + r_x};
                        end
                        MODE_IND_Y: begin
                            n_zp    = data;
                            n_phase = PH_PTR_LO;
                            o_res.address = {8'd0, data};
                        end
                        MODE_ZP: begin
                            n_phase = PH_IDLE;
                            o_res.kind    = KIND_DONE;
                            o_res.address = {8'd0, data};
                        end
                        MODE_ZP_X: begin
                            n_phase = PH_IDLE;
                            o_res.kind    = KIND_DONE;
                            o_res.address = {8'd0, data + r_x};
                        end
                        default: begin
                            n_lo    = data;
                            n_phase = PH_OPER_HI;
                            o_res.address = pc_inc;
                        end
                    endcase
                end
                PH_OPER_HI: begin
                    n_pc    = pc_inc;
                    n_phase = PH_IDLE;
                    o_res.kind    = KIND_DONE;
                    o_res.next_pc = pc_inc;
                    if (r_mode == MODE_ABS_Y) begin
                        o_res.address = word + {8'd0, r_y};
                    end else if (r_mode == MODE_ABS_X) begin
                        o_res.address = word + {8'd0, r_x};
                    end else begin
                        o_res.address = word;
                    end
                end
                PH_PTR_LO: begin
                    // The pointer high byte stays inside page zero.
                    n_lo    = data;
                    n_phase = PH_PTR_HI;
                    o_res.address = {8'd0, r_zp + 8'd1};
                end
                PH_PTR_HI: begin
                    n_phase = PH_IDLE;
                    o_res.kind = KIND_DONE;
                    if (r_mode == MODE_IND_Y) begin
                        o_res.address = word + {8'd0, r_y};
                    end else begin
                        o_res.address = word;
                    end
                end
                default: begin
                    // Read data with no instruction in flight is dropped.
                    n_phase = PH_IDLE;
                    o_res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pc    <= 16'd0;
            r_x     <= 8'd0;
            r_y     <= 8'd0;
            r_mode  <= 3'd0;
            r_op    <= 3'd0;
            r_zp    <= 8'd0;
            r_lo    <= 8'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pc    <= n_pc;
            r_x     <= n_x;
            r_y     <= n_y;
            r_mode  <= n_mode;
            r_op    <= n_op;
            r_zp    <= n_zp;
            r_lo    <= n_lo;
        end
    end

endmodule

### design/gom_out_stage.sv
// Result register that holds one result beat until the sink takes it.
module gom_out_stage
    import gom_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### design/group_one_address_mode_unit.sv
// Top level of the group one addressing unit: ports, stages and checks.
//
//  Channel   Dir  Handshake                    Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: action; tdata: pc, x, y, read data
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser: kind; tdata: address, next pc, aaa
//
// One beat a cycle is accepted when the sink keeps up. The core works on a beat
// while it sits in the input register, and any result it yields is loaded into the
// output register when the beat is taken, so the sink takes it from that register.
// The core state update loops from the core registers back to them through combinational logic.
// Reset is synchronous and active low; it empties both registers and idles the core.
// A stalled sink holds the result register, and the input side stalls behind it.
module group_one_address_mode_unit
    import gom_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [InTdataW-1:0]  s_axis_tdata,   // start_pc, x_index, y_index, read_data
    input  logic                 s_axis_tuser,   // action
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OutTdataW-1:0] m_axis_tdata,   // address, next_pc, operation, zero fill
    output logic [1:0]           m_axis_tuser    // kind
);

    t_in_beat in_beat;
    t_in_beat core_beat;
    t_result  core_res;
    t_result  out_res;
    logic     core_valid;
    logic     res_valid;
    logic     out_free;
    logic     fire;
    logic     busy;

    assign in_beat.action    = t_action'(s_axis_tuser);
    assign in_beat.start_pc  = s_axis_tdata[15:0];
    assign in_beat.x_index   = s_axis_tdata[23:16];
    assign in_beat.y_index   = s_axis_tdata[31:24];
    assign in_beat.read_data = s_axis_tdata[39:32];

    assign fire = core_valid && out_free;

    gom_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_beat  (in_beat),
        .i_take  (fire),
        .o_valid (core_valid),
        .o_beat  (core_beat)
    );

    gom_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_beat      (core_beat),
        .o_res_valid (res_valid),
        .o_res       (core_res),
        .o_busy      (busy)
    );

    gom_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && res_valid),
        .i_res   (core_res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {5'd0, out_res.operation, out_res.next_pc, out_res.address};

`include "group_one_address_mode_unit_assert.svh"

    `GOM_ASSERT_IMP(a_idle_data_dropped, fire && core_beat.action == ACT_DATA && !busy, !res_valid, "read data while idle produced a result")
    `GOM_ASSERT_NEXT(a_final_idles, fire && res_valid && core_res.kind != KIND_READ, !busy, "core still busy after a final result")
    `GOM_ASSERT_IMP(a_reject_pc, m_axis_tvalid && (out_res.kind == KIND_INVALID || out_res.kind == KIND_NOT_G1), out_res.next_pc == out_res.address + 16'd1, "rejected opcode result has wrong next pc")
    `GOM_ASSERT_IMP(a_invalid_op, m_axis_tvalid && out_res.kind == KIND_INVALID, out_res.operation == 3'd0, "invalid opcode result carries an operation")

endmodule
